// ===== sv/loop_detect_lru_loop_cache_core_assert.svh =====
// Assertion macros for the loop cache core.
`ifndef LOOP_DETECT_LRU_LOOP_CACHE_CORE_ASSERT_SVH
`define LOOP_DETECT_LRU_LOOP_CACHE_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LDLC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LDLC_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ldlc_pkg.sv =====
package ldlc_pkg;

    localparam int PC_W     = 64;
    localparam int CNT_W    = 32;
    localparam int RUN_W    = 16;
    localparam int STAT_W   = 32;
    localparam int CFG_W    = 5;
    localparam int WAY_O_W  = 4;
    localparam int S_DATA_W = 160;
    localparam int M_DATA_W = 168;
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_W-1:0]  CFG_RESET = 5'd16;
    localparam logic [RUN_W-1:0]  RUN_ONE   = 16'd1;
    localparam logic [RUN_W-1:0]  RUN_MAX   = 16'hFFFF;
    localparam logic [STAT_W-1:0] STAT_MAX  = 32'hFFFF_FFFF;
    localparam logic [STAT_W-1:0] STAT_ONE  = 32'd1;

    typedef struct packed {
        logic [PC_W-1:0]   end_pc;
        logic [PC_W-1:0]   jump_pc;
        logic [CNT_W-1:0]  instr_count;
        logic              is_iteration;
        logic              new_loop;
        logic [RUN_W-1:0]  iteration_count;
        logic [RUN_W-1:0]  ended_run_iterations;
        logic [STAT_W-1:0] total_instructions;
        logic [STAT_W-1:0] total_loops;
        logic [STAT_W-1:0] stamp;
    } job_t;

    function automatic logic [STAT_W-1:0] sat_add(input logic [STAT_W-1:0] a,
                                                  input logic [STAT_W-1:0] b);
        logic [STAT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[STAT_W] ? STAT_MAX : s[STAT_W-1:0];
    endfunction

endpackage

// ===== sv/ldlc_front.sv =====
module ldlc_front import ldlc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // end_pc, jump_pc, instr_count
    input  logic                q_full,
    output logic                q_push,
    output job_t                q_job
);

    logic [PC_W-1:0]   prev_end_reg,    prev_end_next;
    logic [PC_W-1:0]   prev_target_reg, prev_target_next;
    logic [RUN_W-1:0]  run_reg,         run_next;
    logic [STAT_W-1:0] index_reg,       index_next;
    logic [STAT_W-1:0] instr_reg,       instr_next;
    logic [STAT_W-1:0] loops_reg,       loops_next;

    logic [PC_W-1:0]  in_end;
    logic [PC_W-1:0]  in_target;
    logic [CNT_W-1:0] in_cnt;
    logic             match;
    logic             first_repeat;
    logic [RUN_W-1:0] ended;

    assign in_end    = s_tdata[PC_W-1:0];
    assign in_target = s_tdata[2*PC_W-1:PC_W];
    assign in_cnt    = s_tdata[2*PC_W+CNT_W-1:2*PC_W];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        match            = (in_end == prev_end_reg) && (in_target == prev_target_reg);
        first_repeat     = match && (run_reg == RUN_ONE);
        instr_next       = sat_add(instr_reg, in_cnt);
        loops_next       = first_repeat ? sat_add(loops_reg, STAT_ONE) : loops_reg;
        index_next       = (index_reg == STAT_MAX) ? index_reg : index_reg + STAT_ONE;
        prev_end_next    = prev_end_reg;
        prev_target_next = prev_target_reg;
        ended            = '0;
        if (match) begin
            run_next = (run_reg == RUN_MAX) ? run_reg : run_reg + RUN_ONE;
        end else begin
            run_next         = RUN_ONE;
            ended            = (run_reg > RUN_ONE) ? run_reg : '0;
            prev_end_next    = in_end;
            prev_target_next = in_target;
        end
    end

    always_comb begin
        q_job.end_pc               = in_end;
        q_job.jump_pc              = in_target;
        q_job.instr_count          = in_cnt;
        q_job.is_iteration         = match;
        q_job.new_loop             = first_repeat;
        q_job.iteration_count      = run_next;
        q_job.ended_run_iterations = ended;
        q_job.total_instructions   = instr_next;
        q_job.total_loops          = loops_next;
        q_job.stamp                = index_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_end_reg    <= '0;
            prev_target_reg <= '0;
            run_reg         <= RUN_ONE;
            index_reg       <= '0;
            instr_reg       <= '0;
            loops_reg       <= '0;
        end else if (q_push) begin
            prev_end_reg    <= prev_end_next;
            prev_target_reg <= prev_target_next;
            run_reg         <= run_next;
            index_reg       <= index_next;
            instr_reg       <= instr_next;
            loops_reg       <= loops_next;
        end
    end

endmodule

// ===== sv/ldlc_queue.sv =====
module ldlc_queue import ldlc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head_job,
    output logic full,
    output logic empty
);

    job_t               q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/ldlc_back.sv =====
module ldlc_back import ldlc_pkg::*; #(
    parameter int MAX_WAYS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,
    input  logic                q_empty,
    input  job_t                q_head,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int LEVELS = $clog2(MAX_WAYS);
    localparam int LVL_W  = $clog2(LEVELS + 2);

    typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_TREE, ST_DONE} state_t;

    state_t             state_reg;
    job_t               job_reg;
    logic [CFG_W-1:0]   cfg_reg;
    logic [STAT_W-1:0]  hits_reg;
    logic [STAT_W-1:0]  ihits_reg;
    logic               res_hit_reg;
    logic [WAY_W-1:0]   res_way_reg;
    logic [LVL_W-1:0]   lvl_reg;
    logic               m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic               valid_reg [MAX_WAYS];
    logic [PC_W-1:0]    end_reg   [MAX_WAYS];
    logic [PC_W-1:0]    tgt_reg   [MAX_WAYS];
    logic [CNT_W-1:0]   cnt_reg   [MAX_WAYS];
    logic [STAT_W-1:0]  use_reg   [MAX_WAYS];

    logic               node_act_reg   [MAX_WAYS];
    logic [STAT_W-1:0]  node_stamp_reg [MAX_WAYS];
    logic [WAY_W-1:0]   node_idx_reg   [MAX_WAYS];
    logic               node_act_next   [MAX_WAYS];
    logic [STAT_W-1:0]  node_stamp_next [MAX_WAYS];
    logic [WAY_W-1:0]   node_idx_next   [MAX_WAYS];

    logic [MAX_WAYS-1:0] act;
    logic [MAX_WAYS-1:0] hit_vec;
    logic [MAX_WAYS-1:0] inv_vec;
    logic                hit_any;
    logic                inv_any;
    logic [WAY_W-1:0]    hit_idx;
    logic [WAY_W-1:0]    inv_idx;
    logic                out_free;
    logic                out_load;
    logic                tree_done;
    logic                touch_en;
    logic                fill_en;
    logic [WAY_W-1:0]    fill_idx;
    logic [M_DATA_W-1:0] out_word;

    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            act[i]     = (i == 0) || (int'(cfg_reg) > i);
            hit_vec[i] = act[i] && valid_reg[i] && (end_reg[i] == job_reg.end_pc) &&
                         (tgt_reg[i] == job_reg.jump_pc) &&
                         (cnt_reg[i] == job_reg.instr_count);
            inv_vec[i] = act[i] && !valid_reg[i];
        end
        hit_any = |hit_vec;
        inv_any = |inv_vec;
        hit_idx = '0;
        inv_idx = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_idx = WAY_W'(i);
            end
            if (inv_vec[i]) begin
                inv_idx = WAY_W'(i);
            end
        end
    end

    // pairwise LRU reduction, one tree level per cycle; ties keep the lower way
    for (genvar g = 0; g < MAX_WAYS; g++) begin : g_node
        if (2 * g + 1 < MAX_WAYS) begin : g_pair
            logic take_b;
            assign take_b = node_act_reg[2*g+1] &&
                            (!node_act_reg[2*g] ||
                             (node_stamp_reg[2*g+1] < node_stamp_reg[2*g]));
            assign node_act_next[g]   = node_act_reg[2*g] || node_act_reg[2*g+1];
            assign node_stamp_next[g] = take_b ? node_stamp_reg[2*g+1] : node_stamp_reg[2*g];
            assign node_idx_next[g]   = take_b ? node_idx_reg[2*g+1] : node_idx_reg[2*g];
        end else if (2 * g < MAX_WAYS) begin : g_pass
            assign node_act_next[g]   = node_act_reg[2*g];
            assign node_stamp_next[g] = node_stamp_reg[2*g];
            assign node_idx_next[g]   = node_idx_reg[2*g];
        end else begin : g_none
            assign node_act_next[g]   = 1'b0;
            assign node_stamp_next[g] = '0;
            assign node_idx_next[g]   = '0;
        end
    end

    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = (state_reg == ST_DONE) && out_free;
    assign tree_done = (state_reg == ST_TREE) && (lvl_reg == LVL_W'(LEVELS));
    assign q_pop     = !q_empty &&
                       ((state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_free));

    always_comb begin
        touch_en = 1'b0;
        fill_en  = 1'b0;
        fill_idx = inv_idx;
        if ((state_reg == ST_LOOK) && job_reg.is_iteration) begin
            if (hit_any) begin
                touch_en = 1'b1;
            end else if (inv_any) begin
                fill_en = 1'b1;
            end
        end
        if (tree_done) begin
            fill_en  = 1'b1;
            fill_idx = node_idx_reg[0];
        end
    end

    assign out_word = {1'b0, ihits_reg, hits_reg, job_reg.total_loops,
                       job_reg.total_instructions, WAY_O_W'(res_way_reg), res_hit_reg,
                       job_reg.ended_run_iterations, job_reg.iteration_count,
                       job_reg.new_loop, job_reg.is_iteration};

    always_ff @(posedge aclk) begin
        if (fill_en) begin
            end_reg[fill_idx] <= job_reg.end_pc;
            tgt_reg[fill_idx] <= job_reg.jump_pc;
            cnt_reg[fill_idx] <= job_reg.instr_count;
            use_reg[fill_idx] <= job_reg.stamp;
        end else if (touch_en) begin
            use_reg[hit_idx] <= job_reg.stamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_WAYS; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (fill_en) begin
            valid_reg[fill_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_LOOK) && job_reg.is_iteration && !hit_any && !inv_any) begin
            for (int i = 0; i < MAX_WAYS; i++) begin
                node_act_reg[i]   <= act[i];
                node_stamp_reg[i] <= use_reg[i];
                node_idx_reg[i]   <= WAY_W'(i);
            end
        end else if ((state_reg == ST_TREE) && !tree_done) begin
            for (int i = 0; i < MAX_WAYS; i++) begin
                node_act_reg[i]   <= node_act_next[i];
                node_stamp_reg[i] <= node_stamp_next[i];
                node_idx_reg[i]   <= node_idx_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cfg_reg      <= CFG_RESET;
            hits_reg     <= '0;
            ihits_reg    <= '0;
            lvl_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        job_reg   <= q_head;
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    lvl_reg <= '0;
                    if (job_reg.is_iteration && hit_any) begin
                        res_hit_reg <= 1'b1;
                        res_way_reg <= hit_idx;
                        hits_reg    <= sat_add(hits_reg, STAT_ONE);
                        ihits_reg   <= sat_add(ihits_reg, job_reg.instr_count);
                        state_reg   <= ST_DONE;
                    end else if (job_reg.is_iteration && inv_any) begin
                        res_hit_reg <= 1'b0;
                        res_way_reg <= inv_idx;
                        state_reg   <= ST_DONE;
                    end else if (job_reg.is_iteration) begin
                        res_hit_reg <= 1'b0;
                        res_way_reg <= '0;
                        state_reg   <= ST_TREE;
                    end else begin
                        res_hit_reg <= 1'b0;
                        res_way_reg <= '0;
                        state_reg   <= ST_DONE;
                    end
                end
                ST_TREE: begin
                    if (tree_done) begin
                        res_way_reg <= node_idx_reg[0];
                        state_reg   <= ST_DONE;
                    end else begin
                        lvl_reg <= lvl_reg + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_tdata_reg <= out_word;
                        if (q_pop) begin
                            job_reg   <= q_head;
                            state_reg <= ST_LOOK;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sv/loop_detect_lru_loop_cache_core.sv =====
// Path: a beat accepted on s_tdata goes through the job queue, the lookup state and the
//   done state into the m_tdata register; an LRU replacement adds the tree states between.
// Pacing: the back end takes one job at a time, lookup then output, with the tree states on
//   a replacement; the LRU tree, the output register and m_tready pace the back end.
// Reset: aresetn synchronous, active low; clears counters, run state, way valid bits,
//   the queue and m_tvalid; cache_ways returns to 16.
module loop_detect_lru_loop_cache_core import ldlc_pkg::*; #(
    parameter int MAX_WAYS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,   // cache_ways
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,       // end_pc, jump_pc, instr_count
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata        // is_iteration, new_loop, iteration_count,
                                               // ended_run_iterations, lc_hit, cache_way,
                                               // total_instructions, total_loops,
                                               // loop_hits, instruction_hits, zero pad
);

`include "loop_detect_lru_loop_cache_core_assert.svh"

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    logic m_beat;
    job_t push_job;
    job_t head_job;

    ldlc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    ldlc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    ldlc_back #(
        .MAX_WAYS (MAX_WAYS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_empty     (q_empty),
        .q_head      (head_job),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    assign m_beat = m_tvalid && m_tready;

    `LDLC_ASSERT_NOW(a_hit_needs_iter, m_tvalid && m_tdata[34], m_tdata[0], "hit on non-iteration")
    `LDLC_ASSERT_NOW(a_new_loop_needs_iter, m_tvalid && m_tdata[1], m_tdata[0], "bad new loop")
    `LDLC_ASSERT_NOW(a_run_restart, m_tvalid && !m_tdata[0], m_tdata[17:2] == RUN_ONE, "no restart")
    `LDLC_ASSERT_NXT(a_beat_spacing, m_beat ##1 m_beat, !m_tvalid, "result beats too close")

endmodule
